// File: rtl/nscc_pkg.sv
// Package for the NMEA sentence checksum checker: constants, result type, hex decode.
package nscc_pkg;

    localparam int LEN_W  = 10;
    localparam int CNT_W  = 32;
    localparam int BYTE_W = 8;
    localparam int NIB_W  = 5;

    localparam logic [BYTE_W-1:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [LEN_W-1:0] MIN_LENGTH  = 10'd7;
    localparam logic [LEN_W-1:0] LIMIT_RESET = 10'd192;
    localparam logic [NIB_W-1:0] NIB_INVALID = 5'd16;

    // Register index of the length limit
    localparam logic REG_LENGTH_LIMIT = 1'b0;

    // Result payload: 1 + 10 + 8 + 32 = 51 bits, padded to 56 on the bus
    localparam int RES_W   = 1 + LEN_W + BYTE_W + CNT_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic [CNT_W-1:0]  valid_total;
        logic [BYTE_W-1:0] computed_checksum;
        logic [LEN_W-1:0]  sentence_length;
        logic              checksum_ok;
    } result_t;

    // Decode one ASCII hex digit, either case; non-digits give the invalid marker
    function automatic logic [NIB_W-1:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [NIB_W-1:0] d;
        d = NIB_INVALID;
        if (c inside {[8'h30:8'h39]}) begin
            d = NIB_W'(c - 8'h30);
        end else if (c inside {[8'h41:8'h46]}) begin
            d = NIB_W'(c - 8'h41 + 8'd10);
        end else if (c inside {[8'h61:8'h66]}) begin
            d = NIB_W'(c - 8'h61 + 8'd10);
        end
        return d;
    endfunction

endpackage

// File: rtl/nscc_framer.sv
// Sentence framer: running length, XOR, star tracking, digit capture and valid count.
module nscc_framer
    import nscc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [LEN_W-1:0]  length_limit,
    output logic              res_valid,
    output result_t           res
);

    logic [LEN_W-1:0]  open_len_reg, open_len_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic              star_seen_reg, star_seen_next;
    logic [LEN_W-1:0]  star_pos_reg, star_pos_next;
    logic [NIB_W-1:0]  hi_nib_reg, hi_nib_next;
    logic [NIB_W-1:0]  lo_nib_reg, lo_nib_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [LEN_W:0]    len_plus1;
    logic [LEN_W:0]    star_plus1;
    logic [LEN_W:0]    star_plus2;
    logic              ok;

    assign len_plus1  = {1'b0, open_len_reg} + 1'b1;
    assign star_plus1 = {1'b0, star_pos_reg} + 1'b1;
    assign star_plus2 = {1'b0, star_pos_reg} + 2'd2;

    // Framing and checksum checks for a closing newline
    assign ok = (open_len_reg >= MIN_LENGTH)
             && star_seen_reg
             && (star_plus2 < {1'b0, open_len_reg})
             && !hi_nib_reg[NIB_W-1]
             && !lo_nib_reg[NIB_W-1]
             && (xor_reg == {hi_nib_reg[3:0], lo_nib_reg[3:0]});

    // Step the sentence state for one byte
    always_comb begin
        open_len_next  = open_len_reg;
        xor_next       = xor_reg;
        star_seen_next = star_seen_reg;
        star_pos_next  = star_pos_reg;
        hi_nib_next    = hi_nib_reg;
        lo_nib_next    = lo_nib_reg;
        count_next     = count_reg;
        res_valid      = 1'b0;
        res.checksum_ok       = ok;
        res.sentence_length   = open_len_reg;
        res.computed_checksum = xor_reg;
        res.valid_total       = count_reg + CNT_W'(ok);
        if (byte_accept) begin
            if (rx_byte == CHAR_DOLLAR) begin
                open_len_next  = 10'd1;
                xor_next       = '0;
                star_seen_next = 1'b0;
                star_pos_next  = '0;
                hi_nib_next    = NIB_INVALID;
                lo_nib_next    = NIB_INVALID;
            end else if (open_len_reg != '0) begin
                if (rx_byte == CHAR_NEWLINE) begin
                    res_valid     = 1'b1;
                    count_next    = res.valid_total;
                    open_len_next = '0;
                end else if (len_plus1 >= {1'b0, length_limit}) begin
                    // drop an overlong sentence
                    open_len_next = '0;
                end else begin
                    if (!star_seen_reg) begin
                        if (rx_byte == CHAR_STAR) begin
                            star_seen_next = 1'b1;
                            star_pos_next  = open_len_reg;
                        end else begin
                            xor_next = xor_reg ^ rx_byte;
                        end
                    end else if ({1'b0, open_len_reg} == star_plus1) begin
                        hi_nib_next = hex_digit(rx_byte);
                    end else if ({1'b0, open_len_reg} == star_plus2) begin
                        lo_nib_next = hex_digit(rx_byte);
                    end
                    open_len_next = len_plus1[LEN_W-1:0];
                end
            end
        end
    end

    // Hold the sentence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_len_reg  <= '0;
            xor_reg       <= '0;
            star_seen_reg <= 1'b0;
            star_pos_reg  <= '0;
            hi_nib_reg    <= NIB_INVALID;
            lo_nib_reg    <= NIB_INVALID;
            count_reg     <= '0;
        end else begin
            open_len_reg  <= open_len_next;
            xor_reg       <= xor_next;
            star_seen_reg <= star_seen_next;
            star_pos_reg  <= star_pos_next;
            hi_nib_reg    <= hi_nib_next;
            lo_nib_reg    <= lo_nib_next;
            count_reg     <= count_next;
        end
    end

    a_count_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.checksum_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("valid count did not advance on a good sentence");

    a_count_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_valid && res.checksum_ok) |=> $stable(count_reg))
        else $error("valid count moved without a good sentence");

    a_close_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> open_len_reg == '0)
        else $error("sentence still open after its newline");

endmodule

// File: rtl/nmea_sentence_checksum_checker_unit.sv
// Top level of the NMEA sentence checksum checker: stream ports, register port, result buffer.
//
// The checker takes one received byte per clock on the s_ stream while s_tready is high
// and frames NMEA sentences: '$' opens a sentence, the bytes up to the first '*' are XORed,
// the two bytes after it are read as hex digits, and a newline closing an open sentence
// gives one result transfer on the m_ stream (pass flag, length, computed XOR, running
// count of good sentences). Each byte is handled in the cycle it is accepted by the framer
// state update, so the sustained rate is one byte per cycle while s_tready stays high; a
// result is registered in the result register, or in the skid register while that is held.
// A two-entry output buffer (result register plus skid register) lets bytes keep flowing
// while a result waits; s_tready drops only when both entries are full. The length_limit
// register (APB offset 0, reset 192) sets the length at which an open sentence is dropped
// without a result; write it only while the stream is idle.
module nmea_sentence_checksum_checker_unit
    import nscc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // APB register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Byte input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    // Result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] checksum_ok, [10:1] sentence_length, [18:11] computed_checksum,
    // [50:19] valid_total, [55:51] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [LEN_W-1:0] limit_reg;
    logic             byte_accept;
    logic             res_valid;
    result_t          res;
    logic             m_valid_reg;
    result_t          m_data_reg;
    logic             skid_valid_reg;
    result_t          skid_data_reg;
    logic             take;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_LENGTH_LIMIT);

    // Write the length limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            limit_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32-LEN_W){1'b0}}, limit_reg} : '0;

    assign s_tready    = !skid_valid_reg;
    assign byte_accept = s_tvalid && s_tready;

    nscc_framer u_framer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .rx_byte      (s_tdata),
        .length_limit (limit_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    assign take = m_valid_reg && m_tready;

    // Advance the result register and skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!m_valid_reg || take) begin
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= res_valid;
                end else begin
                    m_valid_reg    <= res_valid;
                end
            end else if (res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || take) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                if (res_valid) begin
                    skid_data_reg <= res;
                end
            end else if (res_valid) begin
                m_data_reg <= res;
            end
        end else if (res_valid) begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, m_data_reg};

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held while result register empty");

    a_stalled_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready && res_valid |=> skid_valid_reg && m_valid_reg)
        else $error("result arriving under stall was lost");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while waiting for transfer");

endmodule
